[rtl/core/amsf_pkg.sv]
// Package: shared widths and signature constants for the manufacturer signature filter.
`timescale 1ns / 1ps
`default_nettype none

package amsf_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned PosW    = 4;
  localparam logic [7:0]  MfrType = 8'hFF;
  localparam logic [3:0]  SigSpan = 4'd10;

  // Expected byte at each signature position of the payload
  function automatic logic [7:0] sig_value(input logic [PosW-1:0] pos);
    logic [7:0] v;
    case (pos)
      4'd0:    v = 8'hC5;
      4'd1:    v = 8'h00;
      4'd6:    v = 8'h01;
      4'd7:    v = 8'h03;
      4'd8:    v = 8'h22;
      4'd9:    v = 8'h02;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Positions that take part in the compare
  function automatic logic sig_check(input logic [PosW-1:0] pos);
    logic c;
    case (pos)
      4'd0, 4'd1, 4'd6, 4'd7, 4'd8, 4'd9: c = 1'b1;
      default:                             c = 1'b0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/amsf_byte_if.sv]
// Interface: byte stream channel into the filter.
`timescale 1ns / 1ps
`default_nettype none

interface amsf_byte_if
  import amsf_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/amsf_result_if.sv]
// Interface: per-report result channel out of the filter.
`timescale 1ns / 1ps
`default_nettype none

interface amsf_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

`default_nettype wire

[rtl/core/adv_manufacturer_signature_filter_core.sv]
// Top level: advertising report parser that flags a manufacturer data signature.
//
// Usage:
//   byte_i   - one word per report byte; last_byte marks the final byte.
//   result_o - one word per report (matched), given after the final byte.
// Each byte is captured in an input register, parsed by a single pass of
// compare logic, and the per-report verdict lands in a result register.
// The verdict is written to the result register once the last byte is parsed.
// Throughput: one byte per cycle outside the stall below, also across report
// boundaries; the result register frees the parser from the receiver.
// Stall: while a result waits untaken, non-final bytes keep flowing; only a
// second final byte holds in the input register, and ready drops once it
// is held there.
// Reset: asynchronous, active low; the parser returns to expect a length
// byte with no match recorded, and both registers are emptied.
// A zero length byte stops parsing until the report ends; a structure that
// runs past the final byte never matches.
`timescale 1ns / 1ps
`default_nettype none

module adv_manufacturer_signature_filter_core
  import amsf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  amsf_byte_if.sink    byte_i,
  amsf_result_if.source result_o
);

  typedef enum logic [1:0] {
    PhLen     = 2'd0,
    PhType    = 2'd1,
    PhPayload = 2'd2,
    PhStop    = 2'd3
  } phase_e;

  // input register
  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             in_last_q;

  // parse state
  phase_e           phase_q, phase_d;
  logic [7:0]       rem_q, rem_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             sig_q, sig_d;
  logic             found_q, found_d;

  // result register
  logic             out_valid_q;
  logic             matched_q;

  logic             step;
  logic [7:0]       rem_dec;
  logic             sig_upd;
  logic [PosW-1:0]  pos_inc;

  // A final byte needs the result slot free (or draining) to move on
  assign step = in_valid_q && (!in_last_q || !out_valid_q || result_o.ready);
  assign byte_i.ready = !in_valid_q || step;

  assign result_o.valid   = out_valid_q;
  assign result_o.matched = matched_q;

  assign rem_dec = rem_q - 8'd1;
  assign pos_inc = pos_q + 4'd1;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    sig_d   = sig_q;
    found_d = found_q;
    sig_upd = sig_q;
    case (phase_q)
      PhLen: begin
        if (in_byte_q == 8'h00) begin
          phase_d = PhStop;
        end else begin
          rem_d   = in_byte_q;
          phase_d = PhType;
        end
      end
      PhType: begin
        rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_d = PhLen;
          pos_d   = '0;
          sig_d   = 1'b1;
        end else begin
          phase_d = PhPayload;
          pos_d   = '0;
          sig_d   = (in_byte_q == MfrType);
        end
      end
      PhPayload: begin
        if (pos_q < SigSpan) begin
          if (sig_check(pos_q) && (in_byte_q != sig_value(pos_q))) begin
            sig_upd = 1'b0;
          end
          pos_d = pos_inc;
        end
        sig_d = sig_upd;
        rem_d = rem_dec;
        if (rem_dec == 8'd0) begin
          // structure complete: decide the match
          if (sig_upd && (pos_d >= SigSpan)) begin
            found_d = 1'b1;
          end
          phase_d = PhLen;
          pos_d   = '0;
          sig_d   = 1'b1;
        end
      end
      default: begin
        // stopped: ignore bytes until the report ends
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhLen;
      rem_q       <= '0;
      pos_q       <= '0;
      sig_q       <= 1'b1;
      found_q     <= 1'b0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (step) begin
        if (in_last_q) begin
          out_valid_q <= 1'b1;
          phase_q     <= PhLen;
          rem_q       <= '0;
          pos_q       <= '0;
          sig_q       <= 1'b1;
          found_q     <= 1'b0;
        end else begin
          phase_q <= phase_d;
          rem_q   <= rem_d;
          pos_q   <= pos_d;
          sig_q   <= sig_d;
          found_q <= found_d;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (byte_i.ready && byte_i.valid) begin
      in_byte_q <= byte_i.data_byte;
      in_last_q <= byte_i.last_byte;
    end
    if (step && in_last_q) begin
      matched_q <= found_d;
    end
  end

`ifndef SYNTHESIS
  // ready only drops behind a held final byte facing a stalled result
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !byte_i.ready |-> (in_valid_q && in_last_q && out_valid_q && !result_o.ready))
    else $error("input stalled without a blocked final byte");

  // inside a payload there is always at least one byte to come
  a_payload_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (rem_q != 8'd0))
    else $error("payload phase with no bytes remaining");

  // position counter saturates at the signature span
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= SigSpan)
    else $error("payload position beyond signature span");

  // a final byte leaves the parser in its reset state with a result pending
  a_report_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_last_q) |=> (phase_q == PhLen && !found_q && pos_q == '0 && out_valid_q))
    else $error("parser not cleared after report end");
`endif

endmodule

`default_nettype wire

[tb/adv_manufacturer_signature_filter_core_tb.sv]
// Self-checking testbench for the advertising report manufacturer signature filter.
`timescale 1ns / 1ps

module adv_manufacturer_signature_filter_core_tb;
  import amsf_pkg::*;

  localparam int unsigned ByteCount  = 1600;     // random stimulus stops past this
  localparam int unsigned QuietFrom  = 1360;     // no idling on either side from here
  localparam int unsigned DrainLimit = 5000;     // cycles allowed for the last verdicts
  localparam int unsigned SettleCyc  = 4;        // cycles waited after the drain loop before the final check

  // Signature bytes and the mask of payload positions that are compared
  localparam logic [7:0] SigByte [10] = '{8'hC5, 8'h00, 8'h00, 8'h00, 8'h00,
                                          8'h00, 8'h01, 8'h03, 8'h22, 8'h02};
  localparam logic [9:0] SigMask      = 10'b11_1100_0011;
  localparam int         SigPos  [6]  = '{0, 1, 6, 7, 8, 9};

  typedef enum logic [1:0] {PhaseLen, PhaseType, PhasePayload, PhaseStop} parse_phase_e;

  typedef enum int {
    KindMatch, KindNearMiss, KindShort, KindWrongType, KindPlain, KindLong
  } struct_kind_e;

  // Per-report verdict predictor plus the queue of verdicts still owed by the block
  class verdict_board;
    parse_phase_e phase;
    logic [7:0]   remaining;
    logic [3:0]   pos;
    logic         sig_ok;
    logic         hit;
    logic         verdicts_due [$];
    int unsigned  mismatches;
    int unsigned  verdicts_seen;
    int unsigned  matches_seen;

    function new();
      clear_report();
      mismatches    = 0;
      verdicts_seen = 0;
      matches_seen  = 0;
    endfunction

    function void clear_structure();
      phase     = PhaseLen;
      remaining = '0;
      pos       = '0;
      sig_ok    = 1'b1;
    endfunction

    function void clear_report();
      clear_structure();
      hit = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      case (phase)
        PhaseLen: begin
          if (b == 8'h00) begin
            phase = PhaseStop;
          end else begin
            remaining = b;
            phase     = PhaseType;
          end
        end
        PhaseType: begin
          sig_ok    = (b == MfrType);
          pos       = '0;
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) clear_structure();
          else phase = PhasePayload;
        end
        PhasePayload: begin
          if (pos < SigSpan) begin
            if (SigMask[pos] && b != SigByte[pos]) sig_ok = 1'b0;
            pos = pos + 4'd1;
          end
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) begin
            if (sig_ok && pos >= SigSpan) hit = 1'b1;
            clear_structure();
          end
        end
        default: ;
      endcase
      if (last) begin
        verdicts_due.push_back(hit);
        clear_report();
      end
    endfunction

    function void check_verdict(logic matched);
      logic due;
      if (verdicts_due.size() == 0) begin
        $error("matched: no verdict expected, actual %0b", matched);
        mismatches++;
        return;
      end
      due = verdicts_due.pop_front();
      verdicts_seen++;
      if (matched === 1'b1) matches_seen++;
      if (matched !== due) begin
        $error("matched: expected %0b, actual %0b", due, matched);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  amsf_byte_if   byte_if ();
  amsf_result_if result_if ();

  adv_manufacturer_signature_filter_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (result_if)
  );

  always #2 clk_i = ~clk_i;

  verdict_board board;
  bit           quiet;          // set for the tail of the run: no idling at all
  int unsigned  idle_pct;       // chance of an idle burst before each word, per report
  int unsigned  bytes_sent;
  int unsigned  reports_sent;
  logic [7:0]   report_bytes [$];

  // Offer one byte word, with an optional idle burst ahead of it, and wait for the take.
  // Ready is read at the edge before any update of that edge lands, so the test
  // below sees exactly what the block saw.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  // Push the report out; the final word carries last_byte. Idling changes per report
  // so that some reports run back to back with no gaps at all.
  task automatic send_report();
    for (int i = 0; i < report_bytes.size(); i++)
      send_byte(report_bytes[i], i == report_bytes.size() - 1);
    reports_sent++;
    if (bytes_sent >= QuietFrom) quiet = 1'b1;
    case ($urandom_range(0, 2))
      0:       idle_pct = 0;
      1:       idle_pct = 25;
      default: idle_pct = 50;
    endcase
  endtask

  function automatic struct_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return KindMatch;
    if (r < 50) return KindNearMiss;
    if (r < 58) return KindShort;
    if (r < 66) return KindWrongType;
    if (r < 99) return KindPlain;
    return KindLong;
  endfunction

  // Append one length-type-value structure. Every kind but a plain one carries the
  // signature at the compared positions; a near miss then has one of them spoilt,
  // a short one stops a byte before the signature is complete.
  task automatic add_structure(input struct_kind_e kind);
    int unsigned plen;
    logic [7:0]  type_b;
    logic [7:0]  payload [$];
    int          idx;
    case (kind)
      KindMatch, KindNearMiss: plen = $urandom_range(10, 16);
      KindShort:               plen = 9;
      KindWrongType:           plen = $urandom_range(10, 13);
      KindLong:                plen = $urandom_range(200, 254);
      default:                 plen = $urandom_range(0, 12);
    endcase
    case (kind)
      KindPlain: type_b = 8'($urandom_range(0, 255));
      KindLong:  type_b = $urandom_range(0, 1) ? MfrType : 8'($urandom_range(0, 255));
      KindWrongType: begin
        do type_b = 8'($urandom_range(0, 255)); while (type_b == MfrType);
      end
      default:   type_b = MfrType;
    endcase
    for (int i = 0; i < plen; i++) payload.push_back(8'($urandom_range(0, 255)));
    if (kind != KindPlain)
      foreach (SigPos[k]) if (SigPos[k] < plen) payload[SigPos[k]] = SigByte[SigPos[k]];
    if (kind == KindNearMiss) begin
      idx = SigPos[$urandom_range(0, 5)];
      payload[idx] = payload[idx] ^ 8'($urandom_range(1, 255));
    end
    report_bytes.push_back(8'(plen + 1));
    report_bytes.push_back(type_b);
    foreach (payload[i]) report_bytes.push_back(payload[i]);
  endtask

  // Mostly well-formed reports; some end in a zero length byte and junk, some are
  // cut short mid-structure, and a few are raw noise.
  task automatic build_report();
    int unsigned roll;
    int unsigned cut;
    report_bytes.delete();
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      repeat ($urandom_range(1, 20)) report_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 4)) add_structure(pick_kind());
    if (roll <= 2) begin
      report_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 6)) report_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (roll <= 4 && report_bytes.size() > 1) begin
      cut = $urandom_range(1, report_bytes.size() - 1);
      repeat (cut) void'(report_bytes.pop_back());
    end
  endtask

  // Result side: random back-pressure bursts, none in the tail of the run
  initial begin
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Every verdict word taken is checked against the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_if.valid && result_if.ready)
      board.check_verdict(result_if.matched);
  end

  initial begin
    int unsigned guard;
    board              = new();
    quiet              = 1'b0;
    idle_pct           = 25;
    bytes_sent         = 0;
    reports_sent       = 0;
    rst_ni            <= 1'b0;
    byte_if.valid     <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.last_byte <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a full match ending on the final byte, with 00 and FF in the free
    // payload bytes
    report_bytes = '{8'h0B, 8'hFF, 8'hC5, 8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA,
                     8'h01, 8'h03, 8'h22, 8'h02};
    send_report();
    // Length one structure, then a zero length byte; the signature byte after it
    // must be ignored
    report_bytes = '{8'h01, 8'h07, 8'h00, 8'hC5};
    send_report();
    // Manufacturer structure cut off by the end of the report
    report_bytes = '{8'h0B, 8'hFF, 8'hC5, 8'h00, 8'h01};
    send_report();
    // One-byte reports: the largest length byte, and a zero length byte, as final
    report_bytes = '{8'hFF};
    send_report();
    report_bytes = '{8'h00};
    send_report();

    // Random reports
    while (bytes_sent < ByteCount) begin
      build_report();
      send_report();
    end
    byte_if.valid <= 1'b0;

    guard = 0;
    while (board.verdicts_due.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCyc) @(posedge clk_i);
    if (board.verdicts_due.size() != 0) begin
      $error("matched: %0d verdicts never arrived", board.verdicts_due.size());
      board.mismatches++;
    end

    $display("Sent %0d reports in %0d byte words; %0d verdicts checked, %0d of them matches.",
             reports_sent, bytes_sent, board.verdicts_seen, board.matches_seen);
    $display("Reports mixed signature hits, near misses, short and cut-off structures, stops.");
    if (board.mismatches == 0) begin
      $display("adv_manufacturer_signature_filter_core_tb: PASS");
    end else begin
      $display("adv_manufacturer_signature_filter_core_tb: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("adv_manufacturer_signature_filter_core_tb: FAIL");
    $finish;
  end

endmodule
